// File: design/window_subarray_target_sum_unit_macros.svh
`ifndef WINDOW_SUBARRAY_TARGET_SUM_UNIT_MACROS_SVH
`define WINDOW_SUBARRAY_TARGET_SUM_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define WSTS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset
`define WSTS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/wsts_pkg.sv
package wsts_pkg;

   // sequence geometry
   localparam int MaxLen       = 1024;
   localparam int ValueBits    = 32;

   // fixed field widths
   localparam int ElementBits  = 32;
   localparam int TargetBits   = 40;
   localparam int PositionBits = 11;

   // derived widths
   localparam int SumBits   = ((TargetBits > ValueBits) ? TargetBits : ValueBits) + 1;
   localparam int HeadBits  = (MaxLen > 1) ? $clog2(MaxLen) : 1;
   localparam int CountBits = $clog2(MaxLen + 1);
   localparam int PosBits   = $clog2(MaxLen + 2);

   // window FIFO control
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } fifo_ctrl_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_SUB    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

// File: design/wsts_req_if.sv
interface wsts_req_if import wsts_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ElementBits-1:0] element_value;
   logic                   last_element;

   modport source (output valid, element_value, last_element, input ready);
   modport sink   (input valid, element_value, last_element, output ready);
endinterface

// File: design/wsts_rsp_if.sv
interface wsts_rsp_if import wsts_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [PositionBits-1:0] start_position;
   logic [PositionBits-1:0] end_position;
   logic                    overflow;

   modport source (output valid, found, start_position, end_position, overflow,
                   input ready);
   modport sink   (input valid, found, start_position, end_position, overflow,
                   output ready);
endinterface

// File: design/wsts_window_fifo.sv
module wsts_window_fifo import wsts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  fifo_ctrl_type        ctrl,
   input  logic [ValueBits-1:0] push_data,
   output logic [ValueBits-1:0] head_data,
   output logic [CountBits-1:0] count
);

   logic [ValueBits-1:0] store_mem [MaxLen];
   logic [ValueBits-1:0] rd_data_ff;
   logic [HeadBits-1:0]  head_ff, head_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [CountBits:0]   tail_raw;
   logic [CountBits:0]   tail_wrap;
   logic [HeadBits-1:0]  tail;

   // tail = head + count, wrapped once around the ring
   always_comb begin
      tail_raw  = (CountBits + 1)'(head_ff) + (CountBits + 1)'(count_ff);
      tail_wrap = (tail_raw >= (CountBits + 1)'(MaxLen)) ?
                  tail_raw - (CountBits + 1)'(MaxLen) : tail_raw;
      tail      = tail_wrap[HeadBits-1:0];
   end

   // head and fill level
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctrl.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (ctrl.push) begin
         count_in = count_ff + CountBits'(1);
      end else if (ctrl.pop) begin
         head_in  = (head_ff == HeadBits'(MaxLen - 1)) ? '0 : head_ff + HeadBits'(1);
         count_in = count_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // window storage: one write port at the tail, registered read of the head
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         store_mem[tail] <= push_data;
      end
      rd_data_ff <= store_mem[head_ff];
   end

   assign head_data = rd_data_ff;
   assign count     = count_ff;

endmodule

// File: design/window_subarray_target_sum_unit.sv
// Finds the first contiguous run of a value sequence whose sum equals the
// target in csr_write_data, and reports its 1-based start and end positions;
// a sequence without a match gives one "not found" item at its last element,
// with overflow set if it ran past 1024 elements. An element passes through
// the states accept, window check and result, plus a subtract and a new check
// for every older value dropped from the window: the subtract takes off the value
// read from the window memory and the check looks at the sum again. Each value
// is dropped at most once. Elements after a match or past the length limit go
// from accept straight to result. A result item waits in an output register,
// and the block stalls only if a second result arrives while the first is still
// untaken.
`include "window_subarray_target_sum_unit_macros.svh"

module window_subarray_target_sum_unit import wsts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   wsts_req_if.sink              req_channel,
   wsts_rsp_if.source            rsp_channel,
   input  logic                  csr_write_enable,
   input  logic [TargetBits-1:0] csr_write_data
);

   state_type               state_ff, state_in;
   logic [TargetBits-1:0]   target_ff;
   logic [SumBits-1:0]      sum_ff, sum_in;
   logic [PosBits-1:0]      pos_ff, pos_in;
   logic                    match_done_ff, match_done_in;
   logic                    last_ff, last_in;
   logic                    hit_ff, hit_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    found_ff, found_in;
   logic [PositionBits-1:0] start_ff, start_in;
   logic [PositionBits-1:0] end_ff, end_in;
   logic                    ovf_ff, ovf_in;

   fifo_ctrl_type           fifo_ctrl;
   logic [ValueBits-1:0]    value;
   logic [ValueBits-1:0]    head_value;
   logic [CountBits-1:0]    fifo_count;
   logic [SumBits-1:0]      target_ext;
   logic                    accept;
   logic                    emit;
   logic                    out_busy;
   logic [PosBits-1:0]      start_calc;

   assign value      = ValueBits'(req_channel.element_value);
   assign target_ext = SumBits'(target_ff);
   assign accept     = req_channel.valid && req_channel.ready;
   assign req_channel.ready = (state_ff == ST_IDLE);

   assign emit       = hit_ff || (last_ff && !match_done_ff);
   assign out_busy   = rsp_valid_ff && !rsp_channel.ready;
   assign start_calc = pos_ff - PosBits'(fifo_count) + PosBits'(1);

   // target register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_write_enable) begin
         target_ff <= csr_write_data;
      end
   end

   // window FIFO
   wsts_window_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (fifo_ctrl),
      .push_data (value),
      .head_data (head_value),
      .count     (fifo_count)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      pos_in        = pos_ff;
      match_done_in = match_done_ff;
      last_in       = last_ff;
      hit_in        = hit_ff;
      fifo_ctrl     = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_channel.ready;
      found_in      = found_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      ovf_in        = ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_channel.last_element;
               if (!match_done_ff && pos_ff < PosBits'(MaxLen)) begin
                  fifo_ctrl.push = 1'b1;
                  sum_in         = sum_ff + SumBits'(value);
                  pos_in         = pos_ff + PosBits'(1);
                  state_in       = ST_CHECK;
               end else begin
                  if (!match_done_ff) begin
                     pos_in = PosBits'(MaxLen + 1);
                  end
                  state_in = ST_FINISH;
               end
            end
         end
         ST_CHECK: begin
            // drop the oldest value while the window sum is too large
            if (fifo_count != '0 && sum_ff > target_ext) begin
               state_in = ST_SUB;
            end else begin
               hit_in   = (fifo_count != '0) && (sum_ff == target_ext);
               state_in = ST_FINISH;
            end
         end
         ST_SUB: begin
            fifo_ctrl.pop = 1'b1;
            sum_in        = sum_ff - SumBits'(head_value);
            state_in      = ST_CHECK;
         end
         ST_FINISH: begin
            if (!(emit && out_busy)) begin
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  found_in     = hit_ff;
                  start_in     = hit_ff ? PositionBits'(start_calc) : '0;
                  end_in       = hit_ff ? PositionBits'(pos_ff) : '0;
                  ovf_in       = !hit_ff && (pos_ff > PosBits'(MaxLen));
               end
               match_done_in = match_done_ff || hit_ff;
               hit_in        = 1'b0;
               // end of sequence: back to an empty window
               if (last_ff) begin
                  fifo_ctrl.clear = 1'b1;
                  sum_in          = '0;
                  pos_in          = '0;
                  match_done_in   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sum_ff        <= '0;
         pos_ff        <= '0;
         match_done_ff <= 1'b0;
         last_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sum_ff        <= sum_in;
         pos_ff        <= pos_in;
         match_done_ff <= match_done_in;
         last_ff       <= last_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      found_ff <= found_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      ovf_ff   <= ovf_in;
   end

   assign rsp_channel.valid          = rsp_valid_ff;
   assign rsp_channel.found          = found_ff;
   assign rsp_channel.start_position = start_ff;
   assign rsp_channel.end_position   = end_ff;
   assign rsp_channel.overflow       = ovf_ff;

   // checks
   `WSTS_ASSERT_IMPLIES(a_pop_nonempty, state_ff == ST_SUB, fifo_count != '0,
      "window drop issued on an empty window")
   `WSTS_ASSERT_IMPLIES(a_count_le_pos, 1'b1, PosBits'(fifo_count) <= pos_ff,
      "window holds more values than elements taken")
   `WSTS_ASSERT_IMPLIES(a_found_span, rsp_valid_ff && found_ff,
      start_ff != '0 && start_ff <= end_ff && !ovf_ff,
      "found item with an inconsistent span")

endmodule
